// ----- sv/stpl_pkg.sv -----
// Shared types, register indexes and glyph/record helpers for the SJIS page layout block.
// Used by stpl_engine, stpl_rsp_fifo and sjis_text_page_layout; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stpl_pkg;

   localparam int unsigned FifoDepth = 4;
   localparam int unsigned PtrWidth  = $clog2(FifoDepth);
   localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);

   localparam logic [7:0]  ByteCr    = 8'h0D;
   localparam logic [7:0]  ByteLf    = 8'h0A;
   localparam logic [9:0]  RowMax    = 10'd1023;
   localparam logic [15:0] PageMax   = 16'hFFFF;

   localparam logic [7:0]  RstMaxCols = 8'd120;
   localparam logic [7:0]  RstMaxRows = 8'd80;
   localparam logic [7:0]  RstMargin  = 8'd16;

   typedef enum logic [2:0] {
      REG_MAX_COLS    = 3'd0,
      REG_MAX_ROWS    = 3'd1,
      REG_MARGIN      = 3'd2,
      REG_BOLD        = 3'd3,
      REG_FONT_SELECT = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_ANK   = 2'd0,
      KIND_KANJI = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] max_cols;
      logic [7:0] max_rows;
      logic [7:0] margin;
      logic       bold;
      logic       font_select;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] page;
      logic [11:0] px;
      logic [14:0] py;
      logic [15:0] code;
      logic [11:0] sx;
      logic [11:0] sy;
      logic        alt;
      logic        last;
   } rec_type;

   typedef struct packed {
      logic [1:0] count;
      rec_type    rec_a;
      rec_type    rec_b;
   } push_type;

   function automatic logic is_lead(input logic [7:0] b);
      return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
   endfunction

   function automatic logic is_trail(input logic [7:0] b);
      return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
   endfunction

   function automatic logic [9:0] row_up(input logic [9:0] r);
      return (r < RowMax) ? r + 10'd1 : r;
   endfunction

   function automatic logic [15:0] to_jis(input logic [7:0] hi_in, input logic [7:0] lo_in);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {hi_in[6:0], 1'b0};
      if (lo_in < 8'h9F) begin
         hi = (hi < 8'h3F) ? hi + 8'h1F : hi - 8'h61;
         lo = (lo_in > 8'h7E) ? lo_in - 8'h20 : lo_in - 8'h1F;
      end else begin
         hi = (hi < 8'h3F) ? hi + 8'h20 : hi - 8'h60;
         lo = lo_in - 8'h7E;
      end
      return {hi, lo};
   endfunction

   function automatic rec_type make_rec(input kind_type kind, input logic [7:0] col,
                                        input logic [9:0] row, input logic [15:0] code,
                                        input logic [15:0] page, input cfg_type cfg);
      rec_type    r;
      logic [11:0] cx;
      logic [14:0] ry;
      logic [7:0]  dlo;
      logic [7:0]  dhi;
      cx  = {1'b0, col, 3'b000} + (cfg.bold ? {4'b0000, col} : 12'd0);
      ry  = {1'b0, row, 4'b0000} + {3'b000, row, 2'b00};
      dlo = code[7:0] - 8'h21;
      dhi = code[15:8] - 8'h21;
      r.kind = kind;
      r.page = page;
      r.px   = {4'b0000, cfg.margin} + cx;
      r.py   = {7'b0000000, cfg.margin} + ry;
      r.code = code;
      r.last = 1'b0;
      if (kind == KIND_ANK) begin
         r.sx  = {5'b00000, code[3:0], 3'b000};
         r.sy  = {4'b0000, code[7:4], 4'b0000};
         r.alt = cfg.font_select;
      end else begin
         r.sx  = {dlo, 4'b0000};
         r.sy  = {dhi, 4'b0000};
         r.alt = 1'b0;
      end
      return r;
   endfunction

   function automatic rec_type make_end(input logic [15:0] page);
      rec_type r;
      r      = '0;
      r.kind = KIND_END;
      r.page = page;
      r.last = 1'b1;
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- sv/stpl_engine.sv -----
// Cursor, page and lead-byte state; builds up to two placement/end records per accepted byte.
// Depends on stpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stpl_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire stpl_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire logic [7:0]        text_byte,
   input  wire logic              end_of_text,
   output stpl_pkg::push_type     push
);

   logic [7:0]  col_ff, col_in;
   logic [9:0]  row_ff, row_in;
   logic [15:0] page_ff, page_in;
   logic        pend_ff, pend_in;
   logic [7:0]  lval_ff, lval_in;
   logic [7:0]  lcol_ff, lcol_in;
   logic [9:0]  lrow_ff, lrow_in;

   logic [7:0]  col0;
   logic [9:0]  row0;
   logic [9:0]  row_lf;
   logic        emit_glyph;
   stpl_pkg::rec_type lead_rec;
   stpl_pkg::rec_type glyph_rec;

   always_comb begin
      lead_rec  = stpl_pkg::make_rec(stpl_pkg::KIND_ANK, lcol_ff, lrow_ff, {8'h00, lval_ff},
                                     page_ff, cfg);
      if (col_ff >= cfg.max_cols) begin
         col0 = 8'd0;
         row0 = stpl_pkg::row_up(row_ff);
      end else begin
         col0 = col_ff;
         row0 = row_ff;
      end
      glyph_rec  = stpl_pkg::make_rec(stpl_pkg::KIND_ANK, col0, row0, {8'h00, text_byte},
                                      page_ff, cfg);
      row_lf     = stpl_pkg::row_up(row0);
      emit_glyph = 1'b0;

      col_in  = col_ff;
      row_in  = row_ff;
      page_in = page_ff;
      pend_in = pend_ff;
      lval_in = lval_ff;
      lcol_in = lcol_ff;
      lrow_in = lrow_ff;
      push    = '0;

      if (accept) begin
         if (end_of_text) begin
            col_in  = 8'd0;
            row_in  = 10'd0;
            page_in = 16'd1;
            pend_in = 1'b0;
            lval_in = 8'd0;
            lcol_in = 8'd0;
            lrow_in = 10'd0;
            if (pend_ff) begin
               push.count = 2'd2;
               push.rec_a = lead_rec;
               push.rec_b = stpl_pkg::make_end(page_ff);
            end else begin
               push.count = 2'd1;
               push.rec_a = stpl_pkg::make_end(page_ff);
            end
         end else if (pend_ff && stpl_pkg::is_trail(text_byte)) begin
            pend_in    = 1'b0;
            col_in     = col0 + 8'd1;
            row_in     = row0;
            push.count = 2'd1;
            push.rec_a = stpl_pkg::make_rec(stpl_pkg::KIND_KANJI, lcol_ff, lrow_ff,
                                            stpl_pkg::to_jis(lval_ff, text_byte),
                                            page_ff, cfg);
            push.rec_a.last = 1'b1;
         end else begin
            pend_in = 1'b0;
            col_in  = col0;
            row_in  = row0;
            priority if (text_byte == stpl_pkg::ByteCr) begin
               col_in = col0;
            end else if (text_byte == stpl_pkg::ByteLf) begin
               col_in = 8'd0;
               if (row_lf >= {2'b00, cfg.max_rows}) begin
                  row_in  = 10'd0;
                  page_in = (page_ff < stpl_pkg::PageMax) ? page_ff + 16'd1 : page_ff;
               end else begin
                  row_in = row_lf;
               end
            end else if (stpl_pkg::is_lead(text_byte)) begin
               pend_in = 1'b1;
               lval_in = text_byte;
               lcol_in = col0;
               lrow_in = row0;
               col_in  = col0 + 8'd1;
            end else begin
               emit_glyph = 1'b1;
               col_in     = col0 + 8'd1;
            end
            push.count = {1'b0, pend_ff} + {1'b0, emit_glyph};
            push.rec_a = pend_ff ? lead_rec : glyph_rec;
            push.rec_a.last = !(pend_ff && emit_glyph);
            push.rec_b = glyph_rec;
            push.rec_b.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= 8'd0;
         row_ff  <= 10'd0;
         page_ff <= 16'd1;
         pend_ff <= 1'b0;
         lval_ff <= 8'd0;
         lcol_ff <= 8'd0;
         lrow_ff <= 10'd0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         page_ff <= page_in;
         pend_ff <= pend_in;
         lval_ff <= lval_in;
         lcol_ff <= lcol_in;
         lrow_ff <= lrow_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/stpl_rsp_fifo.sv -----
// Result queue: takes up to two records per cycle, delivers one per rsp transaction.
// Depends on stpl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stpl_rsp_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stpl_pkg::push_type push,
   output logic                    room,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output stpl_pkg::rec_type       out_rec
);

   stpl_pkg::rec_type mem_ff [stpl_pkg::FifoDepth];

   logic [stpl_pkg::PtrWidth-1:0] wp_ff, wp_in;
   logic [stpl_pkg::PtrWidth-1:0] rp_ff, rp_in;
   logic [stpl_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic [stpl_pkg::PtrWidth-1:0] wp_next;
   logic                          pop;

   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   assign room      = (cnt_ff <= stpl_pkg::CntWidth'(stpl_pkg::FifoDepth - 2));
   assign out_rec   = mem_ff[rp_ff];
   assign wp_next   = wp_ff + stpl_pkg::PtrWidth'(1);

   always_comb begin
      wp_in  = wp_ff + stpl_pkg::PtrWidth'(push.count);
      rp_in  = rp_ff + stpl_pkg::PtrWidth'(pop);
      cnt_in = cnt_ff + stpl_pkg::CntWidth'(push.count) - stpl_pkg::CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wp_ff] <= push.rec_a;
      end
      if (push.count == 2'd2) begin
         mem_ff[wp_next] <= push.rec_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/sjis_text_page_layout.sv -----
// Top level of the SJIS text page layout block: configuration registers, engine, result queue.
// Depends on stpl_pkg, stpl_engine and stpl_rsp_fifo.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | text_byte, end_of_text
//   rsp     | out       | rsp_valid/rsp_ready   | one placement or end record
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One byte per cycle while req_ready is high: state updates in the req transaction's cycle,
// and its zero to two records enter a four-entry queue, shown on rsp from the next cycle.
// A lone lead byte and the plain byte after it give two records; rsp sets sustained rate.
// req_ready drops while fewer than two queue entries are free. csr_ready is always high.
// Synchronous reset restores register defaults and the cursor; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module sjis_text_page_layout (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_record_kind,
   output logic [15:0]      rsp_page_index,
   output logic [11:0]      rsp_pixel_x,
   output logic [14:0]      rsp_pixel_y,
   output logic [15:0]      rsp_glyph_code,
   output logic [11:0]      rsp_font_src_x,
   output logic [11:0]      rsp_font_src_y,
   output logic             rsp_font_alt,
   output logic             rsp_last_of_run,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   stpl_pkg::cfg_type  cfg_ff, cfg_in;
   stpl_pkg::push_type push;
   stpl_pkg::rec_type  out_rec;
   logic               room;
   logic               accept;

   assign csr_ready = 1'b1;
   assign req_ready = room;
   assign accept    = req_valid && room;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            stpl_pkg::REG_MAX_COLS:    cfg_in.max_cols    = csr_data;
            stpl_pkg::REG_MAX_ROWS:    cfg_in.max_rows    = csr_data;
            stpl_pkg::REG_MARGIN:      cfg_in.margin      = csr_data;
            stpl_pkg::REG_BOLD:        cfg_in.bold        = csr_data[0];
            stpl_pkg::REG_FONT_SELECT: cfg_in.font_select = csr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_cols    <= stpl_pkg::RstMaxCols;
         cfg_ff.max_rows    <= stpl_pkg::RstMaxRows;
         cfg_ff.margin      <= stpl_pkg::RstMargin;
         cfg_ff.bold        <= 1'b0;
         cfg_ff.font_select <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stpl_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   stpl_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rec   (out_rec)
   );

   assign rsp_record_kind = out_rec.kind;
   assign rsp_page_index  = out_rec.page;
   assign rsp_pixel_x     = out_rec.px;
   assign rsp_pixel_y     = out_rec.py;
   assign rsp_glyph_code  = out_rec.code;
   assign rsp_font_src_x  = out_rec.sx;
   assign rsp_font_src_y  = out_rec.sy;
   assign rsp_font_alt    = out_rec.alt;
   assign rsp_last_of_run = out_rec.last;

endmodule
`default_nettype wire
